// ===== sv/pcaa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaa_pkg: shared types and constants
// Request codes, register indexes, field widths and the pixel entry layout
// used by the color accumulate and average block.
// ----------------------------------------------------------------------------
package pcaa_pkg;

    localparam int COLOR_W    = 8;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 8;
    localparam int INDEX_W    = 10;
    localparam int FUNC_W     = 2;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int DIVIDEND_W = SUM_W + COLOR_W;
    localparam int DIVISOR_W  = SUM_W;
    localparam int QUOT_W     = COLOR_W;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 1'd1;

    localparam logic [COLOR_W-1:0] MAX_BRIGHTNESS_RST = 8'd255;
    localparam logic [CFG_W-1:0]   PIXEL_COUNT_RST    = 11'd1024;

    localparam logic [SUM_W-1:0] SUM_MAX = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } pixel_entry_t;

    localparam int ENTRY_W = $bits(pixel_entry_t);

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } pcaa_div_sts_t;

endpackage

// ===== sv/pcaa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaa_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pcaa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaa_div: restoring divider with saturation flag
// Produces one quotient bit per cycle. The overflow flag is set when the
// quotient would not fit in QUOT_W bits, in which case the quotient is void.
// ----------------------------------------------------------------------------
module pcaa_div
    import pcaa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output pcaa_div_sts_t         sts
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DIVIDEND_W-1:0] dsh_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic                  ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            rem_reg  <= dividend;
            dsh_reg  <= {1'b0, divisor, {(QUOT_W-1){1'b0}}};
            ovf_reg  <= dividend >= {divisor, {QUOT_W{1'b0}}};
            quot_reg <= '0;
            step_reg <= STEP_W'(QUOT_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            // The divisor shifted into place moves down one bit each step.
            if (rem_reg >= dsh_reg) begin
                rem_reg  <= rem_reg - dsh_reg;
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_reg <= {1'b0, dsh_reg[DIVIDEND_W-1:1]};
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg - 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign sts.quot = quot_reg;

endmodule

// ===== sv/pixel_color_accumulate_average.sv =====
`timescale 1ns / 1ps
// Add request: the pixel entry is read and written back.
// Clear request: min(pixel_count, MAX_PIXELS) entries are zeroed, one entry per cycle.
// Read request: the result is shown once the divider has run the three channels
// one after another, and a stalled earlier result holds the read back until it
// leaves.
// After reset a clearing pass zeroes all MAX_PIXELS entries of the store.
// ----------------------------------------------------------------------------
// pixel_color_accumulate_average: per-pixel color blend store
// Accumulates RGB sums and hit counts per pixel in one RAM and returns the
// brightness-scaled average color of a pixel on a read request.
// ----------------------------------------------------------------------------
module pixel_color_accumulate_average
    import pcaa_pkg::*;
#(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // pixel_index[9:0], red, green, blue, zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func
    // Result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // out_red, out_green, out_blue
);

    localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW  = $clog2(MAX_PIXELS + 1);
    localparam logic [16:0] MAX17 = 17'(MAX_PIXELS);

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_ADD, ST_CLEAR, ST_RD, ST_DSTART, ST_DWAIT, ST_PUSH
    } state_t;

    state_t              state_reg;
    logic [COLOR_W-1:0]  mb_reg;
    logic [CFG_W-1:0]    pc_reg;
    logic [CW-1:0]       clr_cnt_reg;
    logic [CW-1:0]       clr_lim_reg;
    logic [AW-1:0]       addr_reg;
    logic                inside_reg;
    logic                add_we_reg;
    logic [DIVIDEND_W-1:0] prod_reg [3];
    logic [DIVISOR_W-1:0]  den_reg;
    logic                cnt_zero_reg;
    logic [1:0]          ch_reg;
    logic [COLOR_W-1:0]  q_reg [3];
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;

    // Color components are held from acceptance until the write-back cycle.
    logic [COLOR_W-1:0]  red_hold_reg, green_hold_reg, blue_hold_reg;

    logic [INDEX_W-1:0]  s_idx;
    logic [COLOR_W-1:0]  s_red, s_green, s_blue;
    logic [16:0]         s_idx17;
    logic                s_inside;
    logic [AW-1:0]       s_addr;
    logic [16:0]         pc17;
    logic [16:0]         clr_n17;
    logic [CW-1:0]       clr_n;
    logic                clr_last;

    pixel_entry_t        rd_entry;
    pixel_entry_t        wr_entry;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;

    logic [SUM_W:0]      red_add, green_add, blue_add;
    pcaa_div_sts_t       div_sts;
    logic                div_start;
    logic [COLOR_W-1:0]  ch_result;

    always_comb begin
        s_idx    = s_tdata[9:0];
        s_red    = s_tdata[17:10];
        s_green  = s_tdata[25:18];
        s_blue   = s_tdata[33:26];
        s_idx17  = {7'b0, s_idx};
        s_inside = s_idx17 < MAX17;
        s_addr   = s_idx17[AW-1:0];
        pc17     = {6'b0, pc_reg};
        clr_n17  = (pc17 > MAX17) ? MAX17 : pc17;
        clr_n    = clr_n17[CW-1:0];
        clr_last = CW'(clr_cnt_reg + 1'b1) == clr_lim_reg;
    end

    // Read-modify-write of one entry with saturating sums and count.
    always_comb begin
        rd_entry  = pixel_entry_t'(ram_rdata);
        red_add   = {1'b0, rd_entry.red}   + {9'b0, red_hold_reg};
        green_add = {1'b0, rd_entry.green} + {9'b0, green_hold_reg};
        blue_add  = {1'b0, rd_entry.blue}  + {9'b0, blue_hold_reg};
    end

    always_comb begin
        wr_entry = '0;
        ram_we   = 1'b0;
        ram_waddr = clr_cnt_reg[AW-1:0];
        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_ADD: begin
                ram_we    = add_we_reg;
                ram_waddr = addr_reg;
                wr_entry.red   = red_add[SUM_W] ? SUM_MAX : red_add[SUM_W-1:0];
                wr_entry.green = green_add[SUM_W] ? SUM_MAX : green_add[SUM_W-1:0];
                wr_entry.blue  = blue_add[SUM_W] ? SUM_MAX : blue_add[SUM_W-1:0];
                wr_entry.cnt   = (rd_entry.cnt == CNT_MAX) ? rd_entry.cnt
                                                           : rd_entry.cnt + 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pcaa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    assign div_start = (state_reg == ST_DSTART);

    pcaa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg[ch_reg]),
        .divisor  (den_reg),
        .sts      (div_sts)
    );

    // An empty or out-of-range pixel reads as black; otherwise clamp to the
    // brightness, which also covers a quotient that overflowed the divider.
    always_comb begin
        if (cnt_zero_reg || !inside_reg) begin
            ch_result = '0;
        end else if (div_sts.ovf || (div_sts.quot > mb_reg)) begin
            ch_result = mb_reg;
        end else begin
            ch_result = div_sts.quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            mb_reg       <= MAX_BRIGHTNESS_RST;
            pc_reg       <= PIXEL_COUNT_RST;
            clr_cnt_reg  <= '0;
            clr_lim_reg  <= CW'(MAX_PIXELS);
            add_we_reg   <= 1'b0;
            ch_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAX_BRIGHTNESS: mb_reg <= cfg_wdata[COLOR_W-1:0];
                    REG_PIXEL_COUNT:    pc_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_PUSH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT, ST_CLEAR: begin
                    if (clr_last) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= ST_IDLE;
                    end else begin
                        clr_cnt_reg <= CW'(clr_cnt_reg + 1'b1);
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        addr_reg       <= s_addr;
                        inside_reg     <= s_inside;
                        red_hold_reg   <= s_red;
                        green_hold_reg <= s_green;
                        blue_hold_reg  <= s_blue;
                        add_we_reg     <= (s_tuser == FUNC_ADD) && s_inside;
                        case (s_tuser)
                            FUNC_CLEAR: begin
                                if (clr_n != '0) begin
                                    clr_lim_reg <= clr_n;
                                    clr_cnt_reg <= '0;
                                    state_reg   <= ST_CLEAR;
                                end else begin
                                    state_reg   <= ST_ADD;
                                end
                            end
                            FUNC_READ: begin
                                state_reg <= ST_RD;
                            end
                            default: begin
                                state_reg <= ST_ADD;
                            end
                        endcase
                    end
                end
                ST_ADD: begin
                    state_reg <= ST_IDLE;
                end
                ST_RD: begin
                    prod_reg[0]  <= {8'b0, rd_entry.red}   * {16'b0, mb_reg};
                    prod_reg[1]  <= {8'b0, rd_entry.green} * {16'b0, mb_reg};
                    prod_reg[2]  <= {8'b0, rd_entry.blue}  * {16'b0, mb_reg};
                    den_reg      <= {rd_entry.cnt, 8'b0} - {8'b0, rd_entry.cnt};
                    cnt_zero_reg <= (rd_entry.cnt == '0);
                    ch_reg       <= '0;
                    state_reg    <= ST_DSTART;
                end
                ST_DSTART: begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_sts.done) begin
                        q_reg[ch_reg] <= ch_result;
                        if (ch_reg == 2'd2) begin
                            state_reg <= ST_PUSH;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= ST_DSTART;
                        end
                    end
                end
                ST_PUSH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {q_reg[2], q_reg[1], q_reg[0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/pcaa_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaa_chk: port-level checks for the color accumulate and average block
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pcaa_chk
    import pcaa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [23:0]          m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Requests are taken one at a time; no two are accepted back to back.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

    // The store is swept after reset before any request is taken.
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid right after reset");

    // Only a read request may raise a result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && (s_tuser != FUNC_READ) && !m_tvalid |=> !m_tvalid)
        else $error("result raised by a non-read request");

endmodule

bind pixel_color_accumulate_average pcaa_chk u_pcaa_chk (.*);

// ===== dv/pcaa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcaa_checker: result checker for the color accumulate and average block
// Watches the configuration port and both stream channels, keeps its own
// copy of the pixel store, predicts the averaged color of every read request
// and compares each returned color field by field against the oldest one.
// ----------------------------------------------------------------------------
module pcaa_checker
    import pcaa_pkg::*;
#(
    parameter int NUM_PIXELS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [39:0]          s_tdata,   // pixel_index[9:0], red, green, blue, zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,   // out_red, out_green, out_blue
    output int                   fail_count,
    output int                   pending,
    output int                   checked
);

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } color_t;

    logic [SUM_W-1:0]   red_acc   [NUM_PIXELS];
    logic [SUM_W-1:0]   green_acc [NUM_PIXELS];
    logic [SUM_W-1:0]   blue_acc  [NUM_PIXELS];
    logic [CNT_W-1:0]   hits      [NUM_PIXELS];
    logic [COLOR_W-1:0] bright;
    logic [CFG_W-1:0]   span;
    color_t             avg_color_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                                  input logic [COLOR_W-1:0] level);
        logic [SUM_W:0] t;
        t = {1'b0, acc} + {9'd0, level};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

    // Channel average scaled by the brightness, in integer form:
    // floor(sum * bright / (hits * 255)), clamped to bright, black when empty.
    function automatic logic [COLOR_W-1:0] avg_level(input logic [SUM_W-1:0] acc,
                                                      input logic [CNT_W-1:0] n,
                                                      input logic [COLOR_W-1:0] scale);
        int unsigned q;
        if (n == '0) return '0;
        q = (32'(acc) * 32'(scale)) / (32'(n) * 32'd255);
        if (q > 32'(scale)) q = 32'(scale);
        return q[COLOR_W-1:0];
    endfunction

    task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [9:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        int     n;
        color_t c;
        c = '0;
        if (func == FUNC_CLEAR) begin
            n = (int'(span) > NUM_PIXELS) ? NUM_PIXELS : int'(span);
            for (int i = 0; i < n; i++) begin
                red_acc[i]   = '0;
                green_acc[i] = '0;
                blue_acc[i]  = '0;
                hits[i]      = '0;
            end
        end else if (func == FUNC_ADD) begin
            if (int'(idx) < NUM_PIXELS) begin
                red_acc[idx]   = sat_sum(red_acc[idx], r);
                green_acc[idx] = sat_sum(green_acc[idx], g);
                blue_acc[idx]  = sat_sum(blue_acc[idx], b);
                if (hits[idx] != CNT_MAX) hits[idx] = hits[idx] + 1'b1;
            end
        end else if (func == FUNC_READ) begin
            if (int'(idx) < NUM_PIXELS) begin
                c.red   = avg_level(red_acc[idx], hits[idx], bright);
                c.green = avg_level(green_acc[idx], hits[idx], bright);
                c.blue  = avg_level(blue_acc[idx], hits[idx], bright);
            end
            avg_color_q.push_back(c);
        end
        // The remaining code is ignored by the block.
    endtask

    task automatic compare_color(input logic [23:0] data);
        color_t want;
        color_t got;
        got = color_t'(data);
        if (avg_color_q.size() == 0) begin
            $error("result without a pending read: out_red=%0d out_green=%0d out_blue=%0d",
                   got.red, got.green, got.blue);
            fail_count++;
        end else begin
            want = avg_color_q.pop_front();
            checked++;
            if (got.red !== want.red) begin
                $error("out_red mismatch: expected %0d, actual %0d", want.red, got.red);
                fail_count++;
            end
            if (got.green !== want.green) begin
                $error("out_green mismatch: expected %0d, actual %0d", want.green, got.green);
                fail_count++;
            end
            if (got.blue !== want.blue) begin
                $error("out_blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
                fail_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PIXELS; i++) begin
                red_acc[i]   = '0;
                green_acc[i] = '0;
                blue_acc[i]  = '0;
                hits[i]      = '0;
            end
            bright = MAX_BRIGHTNESS_RST;
            span   = PIXEL_COUNT_RST;
            avg_color_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_MAX_BRIGHTNESS) bright = cfg_wdata[COLOR_W-1:0];
                else if (cfg_index == REG_PIXEL_COUNT) span = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[9:0], s_tdata[17:10], s_tdata[25:18],
                              s_tdata[33:26]);
            if (m_tvalid && m_tready)
                compare_color(m_tdata);
        end
        pending = avg_color_q.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the color accumulate and average block
// Drives a short directed sequence and then randomized request streams under
// several brightness and clear-length settings, with bursty stalls on both
// channels; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pcaa_pkg::*;

    localparam int                NUM_PIXELS  = 1024;
    localparam int                SETTLE_CYC  = 1100;  // longer than a full clear
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata   = '0;   // pixel_index[9:0], red, green, blue, zero pad
    logic [FUNC_W-1:0]    s_tuser   = '0;   // func
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;          // out_red, out_green, out_blue

    int   fail_count;
    int   pending;
    int   checked;

    int   n_add, n_read, n_clear, n_unused, n_settings;
    logic rx_calm = 1'b0;
    logic rx_busy = 1'b1;
    int   rx_hold = 0;
    int   rx_tick = 0;

    pixel_color_accumulate_average #(.MAX_PIXELS(NUM_PIXELS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pcaa_checker #(.NUM_PIXELS(NUM_PIXELS)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("** pixel_color_accumulate_average: FAILED **");
        $finish;
    end

    // Result side back-pressure: bursts of stalls of random length, with
    // stretches where the receiver never stalls.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 256 == 0) rx_busy <= ($urandom_range(0, 3) != 0);
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else if (!rx_calm && rx_busy && $urandom_range(0, 99) < 10) begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(input logic [FUNC_W-1:0] func, input logic [9:0] idx,
                        input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, b, g, r, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (func)
            FUNC_CLEAR: n_clear++;
            FUNC_ADD:   n_add++;
            FUNC_READ:  n_read++;
            default:    n_unused++;
        endcase
    endtask

    task automatic pause(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold the request side until every predicted color has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_level(input bit sat);
        if (sat)
            return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(230, 255));
        case ($urandom_range(0, 3))
            2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            3:       return 8'($urandom_range(200, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One register setting followed by a random request stream. In the
    // saturating mode one pixel takes most of the adds, so its sums and its
    // hit count run into their limits.
    task automatic run_phase(input logic [7:0] bright, input logic [10:0] span,
                             input int n_items, input bit sat, input bit quiet);
        logic [9:0]        hot [8];
        logic [FUNC_W-1:0] func;
        logic [9:0]        idx;
        int                roll;
        drain();
        repeat (SETTLE_CYC) @(posedge aclk);
        write_reg(REG_MAX_BRIGHTNESS, {3'd0, bright});
        write_reg(REG_PIXEL_COUNT, span);
        cfg_we <= 1'b0;
        @(posedge aclk);
        n_settings++;
        for (int i = 0; i < 8; i++)
            hot[i] = (i < 4) ? 10'($urandom_range(0, 31)) : 10'($urandom_range(0, 1023));
        for (int k = 0; k < n_items; k++) begin
            if (!quiet && $urandom_range(0, 9) == 0) pause($urandom_range(1, 11));
            if (k == n_items / 2 || $urandom_range(0, 199) == 0) drain();
            roll = $urandom_range(0, 99);
            if (sat) begin
                if (roll < 1)       func = FUNC_UNUSED;
                else if (roll < 82) func = FUNC_ADD;
                else                func = FUNC_READ;
                idx = ($urandom_range(0, 9) != 0) ? hot[0] : 10'($urandom_range(0, 1023));
            end else begin
                if (roll < 3)       func = FUNC_CLEAR;
                else if (roll < 5)  func = FUNC_UNUSED;
                else if (roll < 55) func = FUNC_ADD;
                else                func = FUNC_READ;
                idx = ($urandom_range(0, 9) < 7) ? hot[$urandom_range(0, 7)]
                                                 : 10'($urandom_range(0, 1023));
            end
            send(func, idx, pick_level(sat), pick_level(sat), pick_level(sat));
        end
    endtask

    initial begin
        n_add = 0; n_read = 0; n_clear = 0; n_unused = 0; n_settings = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset register values.
        send(FUNC_READ,  10'd0,    8'h00, 8'h00, 8'h00);   // empty pixel reads black
        send(FUNC_ADD,   10'd0,    8'hFF, 8'hFF, 8'hFF);
        send(FUNC_READ,  10'd0,    8'h00, 8'h00, 8'h00);
        send(FUNC_ADD,   10'd1023, 8'h00, 8'h00, 8'h00);
        send(FUNC_READ,  10'd1023, 8'hFF, 8'hFF, 8'hFF);
        send(FUNC_ADD,   10'd1023, 8'h01, 8'h80, 8'hFE);
        send(FUNC_READ,  10'd1023, 8'h00, 8'h00, 8'h00);
        send(FUNC_ADD,   10'h2AA,  8'hAA, 8'h55, 8'h0F);
        send(FUNC_ADD,   10'h155,  8'h55, 8'hAA, 8'hF0);
        send(FUNC_READ,  10'h2AA,  8'h00, 8'h00, 8'h00);
        send(FUNC_READ,  10'h155,  8'h00, 8'h00, 8'h00);
        send(FUNC_UNUSED, 10'd0,   8'hFF, 8'hFF, 8'hFF);   // ignored code
        send(FUNC_UNUSED, 10'h3FF, 8'h00, 8'h00, 8'h00);
        send(FUNC_READ,  10'd0,    8'h00, 8'h00, 8'h00);
        send(FUNC_CLEAR, 10'h3FF,  8'hFF, 8'hFF, 8'hFF);
        send(FUNC_READ,  10'd0,    8'h00, 8'h00, 8'h00);
        send(FUNC_READ,  10'd1023, 8'h00, 8'h00, 8'h00);
        send(FUNC_READ,  10'h2AA,  8'h00, 8'h00, 8'h00);

        run_phase(8'd255, 11'd1024, 250, 1'b0, 1'b0);
        run_phase(8'd0,   11'd1,    150, 1'b0, 1'b0);
        run_phase(8'd1,   11'd0,    150, 1'b0, 1'b0);   // a clear sweeps nothing
        run_phase(8'd255, 11'd2047, 450, 1'b1, 1'b0);   // clear length above the store
        run_phase(8'($urandom_range(2, 254)), 11'($urandom_range(1, 64)), 200, 1'b0, 1'b0);
        rx_calm <= 1'b1;
        run_phase(8'd128, 11'd1023, 200, 1'b0, 1'b1);

        drain();
        repeat (SETTLE_CYC) @(posedge aclk);
        $display("Sent %0d requests (%0d adds, %0d reads, %0d clears, %0d unused) over %0d settings.",
                 n_add + n_read + n_clear + n_unused, n_add, n_read, n_clear, n_unused,
                 n_settings);
        $display("Compared %0d returned colors against the predicted averages.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** pixel_color_accumulate_average: PASSED **");
        end else begin
            $display("** pixel_color_accumulate_average: FAILED **");
        end
        $finish;
    end

endmodule

// ===== pixel_color_accumulate_average.f =====
sv/pcaa_pkg.sv
sv/pcaa_ram.sv
sv/pcaa_div.sv
sv/pixel_color_accumulate_average.sv
sv/pcaa_chk.sv
dv/pcaa_checker.sv
dv/tb.sv
